// ----- rtl/gnos_pkg.sv -----
// ----------------------------------------------------------------------------
// gnos_pkg
// Shared types, constants, permutation ROM and small arithmetic helpers for
// the gradient noise octave sum block.
// ----------------------------------------------------------------------------
package gnos_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = FRAC_BITS + 4;
    localparam int FREQ_W    = 44;
    localparam int POS_W     = FRAC_BITS + 24;

    localparam logic [16:0] TURB_PERS = 17'd32768;
    localparam logic [19:0] TURB_LAC  = 20'd131072;

    typedef enum logic [1:0] {
        REG_SUM_MODE,
        REG_OCTAVE_COUNT,
        REG_PERSISTENCE,
        REG_LACUNARITY
    } reg_idx_t;

    // effective controls seen by every octave
    typedef struct packed {
        logic        turb;
        logic [3:0]  oct_num;
        logic [16:0] pers;
        logic [19:0] lac;
    } gnos_ctl_t;

    typedef logic [255:0][7:0] perm_tab_t;

    // fixed shuffle of the identity; modulo done by repeated subtraction
    function automatic perm_tab_t build_perm();
        perm_tab_t  tab;
        logic [7:0] tmp;
        int         j;
        int         m;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 8'(i);
        end
        for (int i = 255; i > 0; i--) begin
            j = i * 75 + 23;
            m = i + 1;
            for (int k = 0; k < 76; k++) begin
                if (j >= m) begin
                    j = j - m;
                end
            end
            tmp    = tab[i];
            tab[i] = tab[j];
            tab[j] = tmp;
        end
        return tab;
    endfunction

    localparam perm_tab_t PERM_ROM = build_perm();

    function automatic logic [15:0] ease_sq(logic [15:0] t);
        logic [31:0] p;
        p = 32'(t) * 32'(t);
        return p[31:16];
    endfunction

    function automatic logic [16:0] ease_fin(logic [15:0] t2, logic [15:0] t);
        logic [17:0] k;
        logic [33:0] p;
        k = 18'd196608 - {1'b0, t, 1'b0};
        p = 34'(t2) * 34'(k);
        return p[32:16];
    endfunction

    function automatic logic signed [19:0] corner_grad(logic [2:0] h,
                                                       logic signed [17:0] x,
                                                       logic signed [17:0] y);
        logic signed [19:0] u;
        logic signed [19:0] v;
        logic signed [19:0] a;
        logic signed [19:0] b;
        u = h[2] ? y : x;
        v = h[2] ? x : y;
        a = h[0] ? -u : u;
        b = h[1] ? -(v <<< 1) : (v <<< 1);
        return a + b;
    endfunction

endpackage

// ----- rtl/gnos_octave.sv -----
// ----------------------------------------------------------------------------
// gnos_octave
// One noise octave: lattice split, hashed gradients, smoothstep blend and
// weighted accumulation, eleven register stages. Also steps the octave
// frequency and amplitude for the next octave.
// ----------------------------------------------------------------------------
module gnos_octave import gnos_pkg::*; #(
    parameter int OCT_IDX = 0,
    parameter int AW      = 25,
    parameter int SW      = 29,
    parameter int TW      = 50
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  gnos_ctl_t                ctl,
    input  logic                     in_valid,
    input  logic signed [31:0]       in_cx,
    input  logic signed [31:0]       in_cy,
    input  logic [FREQ_W-1:0]        in_freq,
    input  logic [AW-1:0]            in_amp,
    input  logic signed [TW-1:0]     in_total,
    input  logic [SW-1:0]            in_asum,
    output logic                     out_valid,
    output logic signed [31:0]       out_cx,
    output logic signed [31:0]       out_cy,
    output logic [FREQ_W-1:0]        out_freq,
    output logic [AW-1:0]            out_amp,
    output logic signed [TW-1:0]     out_total,
    output logic [SW-1:0]            out_asum
);

    localparam int NST = 11;
    localparam int PW  = AW + 21;
    localparam logic [4:0] IDX = 5'(OCT_IDX);

    // shift lines carried alongside the work
    logic                 vld_reg  [1:NST];
    logic signed [31:0]   cx_reg   [1:NST];
    logic signed [31:0]   cy_reg   [1:NST];
    logic [AW-1:0]        amp_reg  [1:NST-1];
    logic signed [TW-1:0] tot_reg  [1:NST];
    logic [SW-1:0]        asum_reg [1:NST];
    logic [FREQ_W-1:0]    fn_reg   [2:NST];
    logic [AW-1:0]        an_reg   [2:NST];

    // stage 1
    logic [POS_W-1:0] pxl_reg, pyl_reg;
    logic [19:0]      pxh_reg, pyh_reg;
    logic [41:0]      fh_reg, fl_reg;
    logic [AW+16:0]   ah_reg;
    // stage 2
    logic [7:0]  xi2_reg, yi2_reg;
    logic [15:0] xf2_reg, yf2_reg;
    // stage 3
    logic [7:0]  xa3_reg, xb3_reg, yi3_reg;
    logic [15:0] xf3_reg, yf3_reg, t2x3_reg, t2y3_reg;
    // stage 4
    logic [2:0]  haa4_reg, hab4_reg, hba4_reg, hbb4_reg;
    logic [15:0] xf4_reg, yf4_reg;
    logic [16:0] sx4_reg, sy4_reg;
    // stage 5
    logic signed [19:0] g1_5_reg, g2_5_reg, g3_5_reg, g4_5_reg;
    logic [16:0]        sx5_reg, sy5_reg;
    // stage 6
    logic signed [38:0] dt6_reg, db6_reg;
    logic signed [19:0] g1_6_reg, g3_6_reg;
    logic [16:0]        sy6_reg;
    // stage 7
    logic signed [19:0] top7_reg, bot7_reg;
    logic [16:0]        sy7_reg;
    // stage 8
    logic signed [38:0] dv8_reg;
    logic signed [19:0] top8_reg;
    // stage 9, 10
    logic signed [19:0]   nv9_reg;
    logic signed [PW-1:0] pr10_reg;

    logic signed [52:0] pxl_full, pyl_full;
    logic [39:0]        pxh_full, pyh_full;
    logic [POS_W-1:0]   px_sum, py_sum;
    logic [63:0]        f_full;
    logic [47:0]        f_shr;
    logic [FREQ_W-1:0]  f_next;
    logic [7:0]         xb_idx, hab_idx, haa_idx, hba_idx, hbb_idx;
    logic signed [17:0] x0, x1, y0, y1;
    logic [20:0]        dt_diff, db_diff, dv_diff;
    logic signed [22:0] top_sum, bot_sum, nv_sum;
    logic signed [19:0] nv_raw;
    logic               active;

    assign pxl_full = in_cx * $signed({1'b0, in_freq[19:0]});
    assign pyl_full = in_cy * $signed({1'b0, in_freq[19:0]});
    assign pxh_full = 40'(in_cx[19:0]) * 40'(in_freq[39:20]);
    assign pyh_full = 40'(in_cy[19:0]) * 40'(in_freq[39:20]);

    assign px_sum = pxl_reg + {pxh_reg, 20'd0};
    assign py_sum = pyl_reg + {pyh_reg, 20'd0};

    assign f_full = {fh_reg, 22'd0} + {22'd0, fl_reg};
    assign f_shr  = f_full[63:16];
    assign f_next = (|f_shr[47:FREQ_W]) ? '1 : f_shr[FREQ_W-1:0];

    assign xb_idx  = xi2_reg + 8'd1;
    assign haa_idx = xa3_reg + yi3_reg;
    assign hab_idx = xa3_reg + yi3_reg + 8'd1;
    assign hba_idx = xb3_reg + yi3_reg;
    assign hbb_idx = xb3_reg + yi3_reg + 8'd1;

    // far corners sit one cell away: fraction minus one
    assign x0 = $signed({2'b00, xf4_reg});
    assign x1 = $signed({2'b11, xf4_reg});
    assign y0 = $signed({2'b00, yf4_reg});
    assign y1 = $signed({2'b11, yf4_reg});

    assign dt_diff = {g2_5_reg[19], g2_5_reg} - {g1_5_reg[19], g1_5_reg};
    assign db_diff = {g4_5_reg[19], g4_5_reg} - {g3_5_reg[19], g3_5_reg};
    assign top_sum = g1_6_reg + $signed(dt6_reg[38:16]);
    assign bot_sum = g3_6_reg + $signed(db6_reg[38:16]);
    assign dv_diff = {bot7_reg[19], bot7_reg} - {top7_reg[19], top7_reg};
    assign nv_sum  = top8_reg + $signed(dv8_reg[38:16]);
    assign nv_raw  = nv_sum[19:0];

    assign active = ({1'b0, ctl.oct_num} > IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= NST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= NST; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[1]   <= in_cx;
            cy_reg[1]   <= in_cy;
            amp_reg[1]  <= in_amp;
            tot_reg[1]  <= in_total;
            asum_reg[1] <= in_asum;
            for (int k = 2; k <= NST; k++) begin
                cx_reg[k] <= cx_reg[k-1];
                cy_reg[k] <= cy_reg[k-1];
            end
            for (int k = 2; k <= NST-1; k++) begin
                amp_reg[k]  <= amp_reg[k-1];
                tot_reg[k]  <= tot_reg[k-1];
                asum_reg[k] <= asum_reg[k-1];
            end
            fn_reg[2] <= f_next;
            an_reg[2] <= ah_reg[AW+15:16];
            for (int k = 3; k <= NST; k++) begin
                fn_reg[k] <= fn_reg[k-1];
                an_reg[k] <= an_reg[k-1];
            end

            // stage 1: partial products of position, next frequency, next amplitude
            pxl_reg <= pxl_full[POS_W-1:0];
            pyl_reg <= pyl_full[POS_W-1:0];
            pxh_reg <= pxh_full[19:0];
            pyh_reg <= pyh_full[19:0];
            fh_reg  <= 42'(in_freq[43:22]) * 42'(ctl.lac);
            fl_reg  <= 42'(in_freq[21:0]) * 42'(ctl.lac);
            ah_reg  <= (AW+17)'(in_amp) * (AW+17)'(ctl.pers);

            // stage 2: cell and fraction, wrapped to 256 cells
            xi2_reg <= px_sum[POS_W-1:POS_W-8];
            yi2_reg <= py_sum[POS_W-1:POS_W-8];
            xf2_reg <= px_sum[31:16];
            yf2_reg <= py_sum[31:16];

            // stage 3
            xa3_reg  <= PERM_ROM[xi2_reg];
            xb3_reg  <= PERM_ROM[xb_idx];
            yi3_reg  <= yi2_reg;
            xf3_reg  <= xf2_reg;
            yf3_reg  <= yf2_reg;
            t2x3_reg <= ease_sq(xf2_reg);
            t2y3_reg <= ease_sq(yf2_reg);

            // stage 4
            haa4_reg <= PERM_ROM[haa_idx][2:0];
            hab4_reg <= PERM_ROM[hab_idx][2:0];
            hba4_reg <= PERM_ROM[hba_idx][2:0];
            hbb4_reg <= PERM_ROM[hbb_idx][2:0];
            xf4_reg  <= xf3_reg;
            yf4_reg  <= yf3_reg;
            sx4_reg  <= ease_fin(t2x3_reg, xf3_reg);
            sy4_reg  <= ease_fin(t2y3_reg, yf3_reg);

            // stage 5
            g1_5_reg <= corner_grad(haa4_reg, x0, y0);
            g2_5_reg <= corner_grad(hba4_reg, x1, y0);
            g3_5_reg <= corner_grad(hab4_reg, x0, y1);
            g4_5_reg <= corner_grad(hbb4_reg, x1, y1);
            sx5_reg  <= sx4_reg;
            sy5_reg  <= sy4_reg;

            // stage 6, 7: blend along x
            dt6_reg  <= $signed(dt_diff) * $signed({1'b0, sx5_reg});
            db6_reg  <= $signed(db_diff) * $signed({1'b0, sx5_reg});
            g1_6_reg <= g1_5_reg;
            g3_6_reg <= g3_5_reg;
            sy6_reg  <= sy5_reg;
            top7_reg <= top_sum[19:0];
            bot7_reg <= bot_sum[19:0];
            sy7_reg  <= sy6_reg;

            // stage 8, 9: blend along y, then absolute value in turbulence mode
            dv8_reg  <= $signed(dv_diff) * $signed({1'b0, sy7_reg});
            top8_reg <= top7_reg;
            nv9_reg  <= (ctl.turb && nv_raw[19]) ? -nv_raw : nv_raw;

            // stage 10, 11: weight and accumulate
            pr10_reg <= nv9_reg * $signed({1'b0, amp_reg[9]});
            tot_reg[NST]  <= tot_reg[NST-1] + (active ? TW'(pr10_reg) : '0);
            asum_reg[NST] <= asum_reg[NST-1] + (active ? SW'(amp_reg[NST-1]) : '0);
        end
    end

    assign out_valid = vld_reg[NST];
    assign out_cx    = cx_reg[NST];
    assign out_cy    = cy_reg[NST];
    assign out_freq  = fn_reg[NST];
    assign out_amp   = an_reg[NST];
    assign out_total = tot_reg[NST];
    assign out_asum  = asum_reg[NST];

endmodule

// ----- rtl/gradient_noise_octave_sum.sv -----
// Pipeline: input register, eleven stages per octave, a 22-stage restoring
// divider (load stage plus one stage per quotient bit) and the output register.
// Throughput: one word per cycle; the whole pipe holds only while a result
// waits in the output register and m_ready is low.
// Reset: synchronous, active low; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// gradient_noise_octave_sum
// Two-dimensional gradient noise summed over octaves, fractal or turbulence,
// with an APB-style register port.
// ----------------------------------------------------------------------------
module gradient_noise_octave_sum import gnos_pkg::*; #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [31:0]      s_coord_x,
    input  logic signed [31:0]      s_coord_y,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_noise_value
);

    localparam int AW = MAX_OCTAVES + 17;
    localparam int SW = AW + $clog2(MAX_OCTAVES) + 1;
    localparam int TW = AW + $clog2(MAX_OCTAVES) + 22;
    localparam int QB = OUT_W + 1;
    localparam int CW = ((TW > SW + QB) ? TW : SW + QB) + 1;

    // ---------------- registers ----------------
    logic        sum_mode_reg;
    logic [3:0]  oct_cnt_reg;
    logic [16:0] pers_reg;
    logic [19:0] lac_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;
    gnos_ctl_t   ctl;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_mode_reg <= 1'b0;
            oct_cnt_reg  <= 4'd4;
            pers_reg     <= 17'd32768;
            lac_reg      <= 20'd131072;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SUM_MODE:     sum_mode_reg <= pwdata[0];
                REG_OCTAVE_COUNT: oct_cnt_reg  <= pwdata[3:0];
                REG_PERSISTENCE:  pers_reg     <= pwdata[16:0];
                REG_LACUNARITY:   lac_reg      <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SUM_MODE:     prdata = {31'd0, sum_mode_reg};
            REG_OCTAVE_COUNT: prdata = {28'd0, oct_cnt_reg};
            REG_PERSISTENCE:  prdata = {15'd0, pers_reg};
            REG_LACUNARITY:   prdata = {12'd0, lac_reg};
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        ctl.turb = sum_mode_reg;
        if (oct_cnt_reg == 4'd0) begin
            ctl.oct_num = 4'd1;
        end else if ({1'b0, oct_cnt_reg} > 5'(MAX_OCTAVES)) begin
            ctl.oct_num = 4'(MAX_OCTAVES);
        end else begin
            ctl.oct_num = oct_cnt_reg;
        end
        ctl.pers = sum_mode_reg ? TURB_PERS : pers_reg;
        ctl.lac  = sum_mode_reg ? TURB_LAC : lac_reg;
    end

    // ---------------- pipe control ----------------
    logic adv;
    logic m_valid_reg;
    logic signed [OUT_W-1:0] m_noise_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    logic               in_vld_reg;
    logic signed [31:0] in_cx_reg, in_cy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_cx_reg <= s_coord_x;
            in_cy_reg <= s_coord_y;
        end
    end

    // ---------------- octave chain ----------------
    logic                 ch_vld   [0:MAX_OCTAVES];
    logic signed [31:0]   ch_cx    [0:MAX_OCTAVES];
    logic signed [31:0]   ch_cy    [0:MAX_OCTAVES];
    logic [FREQ_W-1:0]    ch_freq  [0:MAX_OCTAVES];
    logic [AW-1:0]        ch_amp   [0:MAX_OCTAVES];
    logic signed [TW-1:0] ch_total [0:MAX_OCTAVES];
    logic [SW-1:0]        ch_asum  [0:MAX_OCTAVES];

    assign ch_vld[0]   = in_vld_reg;
    assign ch_cx[0]    = in_cx_reg;
    assign ch_cy[0]    = in_cy_reg;
    assign ch_freq[0]  = FREQ_W'(65536);
    assign ch_amp[0]   = AW'(65536);
    assign ch_total[0] = '0;
    assign ch_asum[0]  = '0;

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
        gnos_octave #(
            .OCT_IDX (g),
            .AW      (AW),
            .SW      (SW),
            .TW      (TW)
        ) u_oct (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .ctl       (ctl),
            .in_valid  (ch_vld[g]),
            .in_cx     (ch_cx[g]),
            .in_cy     (ch_cy[g]),
            .in_freq   (ch_freq[g]),
            .in_amp    (ch_amp[g]),
            .in_total  (ch_total[g]),
            .in_asum   (ch_asum[g]),
            .out_valid (ch_vld[g+1]),
            .out_cx    (ch_cx[g+1]),
            .out_cy    (ch_cy[g+1]),
            .out_freq  (ch_freq[g+1]),
            .out_amp   (ch_amp[g+1]),
            .out_total (ch_total[g+1]),
            .out_asum  (ch_asum[g+1])
        );
    end

    // ---------------- divider ----------------
    logic                 dv_vld_reg [0:QB];
    logic [CW-1:0]        dv_rem_reg [0:QB];
    logic [SW-1:0]        dv_den_reg [0:QB];
    logic [QB-1:0]        dv_q_reg   [0:QB];
    logic                 dv_neg_reg [0:QB];
    logic [OUT_W-1:0]     dv_tr_reg  [0:QB];
    logic [CW-1:0]        dv_shd     [1:QB];

    logic signed [TW-1:0] tot_fin;
    logic [TW-1:0]        tot_mag;
    logic signed [TW-1:0] tot_shr;
    logic [OUT_W-1:0]     turb_sat;

    localparam logic signed [TW-1:0] LIM_HI = TW'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [TW-1:0] LIM_LO = TW'(-(1 << (OUT_W - 1)));
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    assign tot_fin = ch_total[MAX_OCTAVES];
    assign tot_mag = tot_fin[TW-1] ? TW'(-tot_fin) : TW'(tot_fin);
    assign tot_shr = tot_fin >>> FRAC_BITS;

    always_comb begin
        if (tot_shr > LIM_HI) begin
            turb_sat = OUT_MAX;
        end else if (tot_shr < LIM_LO) begin
            turb_sat = OUT_MIN;
        end else begin
            turb_sat = tot_shr[OUT_W-1:0];
        end
    end

    always_comb begin
        for (int k = 1; k <= QB; k++) begin
            dv_shd[k] = CW'(dv_den_reg[k-1]) << (QB - k);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QB; k++) begin
                dv_vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            dv_vld_reg[0] <= ch_vld[MAX_OCTAVES];
            for (int k = 1; k <= QB; k++) begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
        end
    end

    // one quotient bit per stage, most significant first
    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0] <= CW'(tot_mag);
            dv_den_reg[0] <= ch_asum[MAX_OCTAVES];
            dv_q_reg[0]   <= '0;
            dv_neg_reg[0] <= tot_fin[TW-1];
            dv_tr_reg[0]  <= turb_sat;
            for (int k = 1; k <= QB; k++) begin
                dv_den_reg[k] <= dv_den_reg[k-1];
                dv_neg_reg[k] <= dv_neg_reg[k-1];
                dv_tr_reg[k]  <= dv_tr_reg[k-1];
                if (dv_rem_reg[k-1] >= dv_shd[k]) begin
                    dv_rem_reg[k] <= dv_rem_reg[k-1] - dv_shd[k];
                    dv_q_reg[k]   <= dv_q_reg[k-1] | (QB'(1) << (QB - k));
                end else begin
                    dv_rem_reg[k] <= dv_rem_reg[k-1];
                    dv_q_reg[k]   <= dv_q_reg[k-1];
                end
            end
        end
    end

    // ---------------- output ----------------
    logic [QB-1:0]    q_fin;
    logic             q_big;
    logic [OUT_W-1:0] frac_res;

    assign q_fin = dv_q_reg[QB];
    assign q_big = |q_fin[QB-1:OUT_W-1];

    always_comb begin
        if (dv_neg_reg[QB]) begin
            frac_res = q_big ? OUT_MIN : OUT_W'(-q_fin[OUT_W-1:0]);
        end else begin
            frac_res = q_big ? OUT_MAX : q_fin[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_vld_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_noise_reg <= ctl.turb ? dv_tr_reg[QB] : frac_res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = m_noise_reg;

    // ---------------- checks ----------------
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while a result is held");

    a_den_at_least_one: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[0] |-> (dv_den_reg[0] >= SW'(65536)))
        else $error("amplitude total below one");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_vld_reg[QB] && !q_fin[QB-1]) |-> (dv_rem_reg[QB] < CW'(dv_den_reg[QB])))
        else $error("divider remainder not reduced");

endmodule
